@@ design/i2c_master_byte_engine_core_assert.svh @@
// ----------------------------------------------------------------------------
// i2c master byte engine assertion macros
// concurrent checks on clk, disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef I2C_MASTER_BYTE_ENGINE_CORE_ASSERT_SVH
`define I2C_MASTER_BYTE_ENGINE_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
`define I2CMBE_ASSERT(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("i2c master byte engine check failed");
`define I2CMBE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("i2c master byte engine check failed");
`define I2CMBE_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("i2c master byte engine check failed");
`else
`define I2CMBE_ASSERT(lbl, expr)
`define I2CMBE_ASSERT_IMP(lbl, ante, cons)
`define I2CMBE_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

@@ design/i2cmbe_pkg.sv @@
// ----------------------------------------------------------------------------
// i2c master byte engine package
// command codes, phase limits and the state and result structs
// ----------------------------------------------------------------------------
package i2cmbe_pkg;

  localparam int BITS_PER_BYTE = 8;

  localparam logic [4:0] START_LAST = 5'd3;
  localparam logic [4:0] STOP_LAST  = 5'd2;
  localparam logic [4:0] BIT_PHASES = 5'(2 * BITS_PER_BYTE);
  localparam logic [4:0] XFER_LAST  = 5'(2 * BITS_PER_BYTE + 1);

  typedef enum logic [2:0] {
    CMD_NONE  = 3'd0,
    CMD_START = 3'd1,
    CMD_STOP  = 3'd2,
    CMD_WRITE = 3'd3,
    CMD_READ  = 3'd4
  } cmd_t;

  typedef struct packed {
    cmd_t                     active;
    logic [4:0]               phase;
    logic [BITS_PER_BYTE-1:0] shift;
    logic [BITS_PER_BYTE-1:0] rx;
    logic                     ack_flag;
    logic                     ack_choice;
    logic                     scl;
    logic                     sda;
    logic                     sda_rel;
  } st_t;

  // lowest member last so it lands in bit 0
  typedef struct packed {
    logic                     ack_seen;
    logic [BITS_PER_BYTE-1:0] rx_byte;
    logic                     done_res;
    logic                     busy_res;
    logic                     sda_drive;
    logic                     sda_level;
    logic                     scl_drive;
    logic                     scl_level;
  } res_t;

endpackage

@@ design/i2c_master_byte_engine_core.sv @@
// ----------------------------------------------------------------------------
// i2c master byte engine core
// start, stop, byte write and byte read sequencer, one word per half-period
// ----------------------------------------------------------------------------
//  channel | ports                        | word
//  input   | in_tvalid/in_tready/in_tdata | command, tx_byte, send_ack, sda_sample
//  result  | out_tvalid/out_tready/out_tdata | line levels, status, rx_byte, ack
//  config  | cfg_valid/cfg_ready/cfg_data | push_pull_mode
//
// the step logic sits between the state registers and the result register,
// so a word is taken every cycle the result is free or being taken. reset
// clears the sequencer to idle with both lines high.
// a stalled result holds in_tready low until it is taken.
// ----------------------------------------------------------------------------
`include "i2c_master_byte_engine_core_assert.svh"

module i2c_master_byte_engine_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // command[2:0], tx_byte[10:3], send_ack[11], sda_sample[12], zero[15:13]
  input  logic [15:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // scl_level[0], scl_drive[1], sda_level[2], sda_drive[3], busy_res[4],
  // done_res[5], rx_byte[13:6], ack_seen[14], zero[15]
  output logic [15:0] out_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data
);

  i2cmbe_pkg::st_t  state_r;
  i2cmbe_pkg::st_t  state_nxt;
  i2cmbe_pkg::res_t res_nxt;
  logic             pp_mode_r;
  logic             out_valid_r;
  logic [15:0]      out_data_r;
  logic             in_acc;

  assign in_tready  = !out_valid_r || out_tready;
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign cfg_ready  = 1'b1;

  i2cmbe_step u_step (
    .state_i    (state_r),
    .pp_mode_i  (pp_mode_r),
    .cmd_i      (in_tdata[2:0]),
    .tx_byte_i  (in_tdata[10:3]),
    .send_ack_i (in_tdata[11]),
    .sda_in_i   (in_tdata[12]),
    .state_o    (state_nxt),
    .res_o      (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pp_mode_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      pp_mode_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.active     <= i2cmbe_pkg::CMD_NONE;
      state_r.phase      <= '0;
      state_r.shift      <= '0;
      state_r.rx         <= '0;
      state_r.ack_flag   <= 1'b1;
      state_r.ack_choice <= 1'b0;
      state_r.scl        <= 1'b1;
      state_r.sda        <= 1'b1;
      state_r.sda_rel    <= 1'b0;
    end else if (in_acc) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_data_r <= {1'b0, res_nxt};
    end
  end

  `I2CMBE_ASSERT(a_phase_range, state_r.phase <= i2cmbe_pkg::XFER_LAST)
  `I2CMBE_ASSERT_IMP(a_idle_phase, state_r.active == i2cmbe_pkg::CMD_NONE, state_r.phase == 5'd0)
  `I2CMBE_ASSERT_IMP(a_done_busy, out_valid_r && out_data_r[5], out_data_r[4])
  `I2CMBE_ASSERT_NXT(a_state_hold, !in_acc, $stable(state_r))
  `I2CMBE_ASSERT_NXT(a_word_out, in_acc, out_valid_r)

endmodule

@@ design/i2cmbe_step.sv @@
// ----------------------------------------------------------------------------
// i2c master byte engine half-period step
// next sequencer state and line levels for one half-period word
// ----------------------------------------------------------------------------
module i2cmbe_step (
  input  i2cmbe_pkg::st_t                         state_i,
  input  logic                                    pp_mode_i,
  input  logic [2:0]                              cmd_i,
  input  logic [i2cmbe_pkg::BITS_PER_BYTE-1:0]    tx_byte_i,
  input  logic                                    send_ack_i,
  input  logic                                    sda_in_i,
  output i2cmbe_pkg::st_t                         state_o,
  output i2cmbe_pkg::res_t                        res_o
);

  localparam int MSB = i2cmbe_pkg::BITS_PER_BYTE - 1;

  i2cmbe_pkg::st_t s;
  logic [4:0]      last;
  logic            busy;
  logic            done;

  always_comb begin
    s    = state_i;
    last = '0;
    busy = 1'b0;
    done = 1'b0;

    if (s.active == i2cmbe_pkg::CMD_NONE &&
        cmd_i >= i2cmbe_pkg::CMD_START && cmd_i <= i2cmbe_pkg::CMD_READ) begin
      s.active = i2cmbe_pkg::cmd_t'(cmd_i);
      s.phase  = '0;
      if (cmd_i == i2cmbe_pkg::CMD_WRITE) begin
        s.shift = tx_byte_i;
      end else if (cmd_i == i2cmbe_pkg::CMD_READ) begin
        s.shift = '0;
      end
      s.ack_choice = send_ack_i;
    end

    if (s.active != i2cmbe_pkg::CMD_NONE) begin
      busy = 1'b1;
      unique case (s.active)
        i2cmbe_pkg::CMD_START: begin
          last = i2cmbe_pkg::START_LAST;
          if (s.phase == 5'd0) begin
            s.sda = 1'b1; s.sda_rel = 1'b0;
          end else if (s.phase == 5'd1) begin
            s.scl = 1'b1;
          end else if (s.phase == 5'd2) begin
            s.sda = 1'b0; s.sda_rel = 1'b0;
          end else begin
            s.scl = 1'b0;
          end
        end
        i2cmbe_pkg::CMD_STOP: begin
          last = i2cmbe_pkg::STOP_LAST;
          if (s.phase == 5'd0) begin
            s.sda = 1'b0; s.sda_rel = 1'b0;
          end else if (s.phase == 5'd1) begin
            s.scl = 1'b1;
          end else begin
            s.sda = 1'b1; s.sda_rel = 1'b0;
          end
        end
        i2cmbe_pkg::CMD_WRITE: begin
          last = i2cmbe_pkg::XFER_LAST;
          if (s.phase < i2cmbe_pkg::BIT_PHASES) begin
            if (!s.phase[0]) begin
              if (s.phase != 5'd0) s.scl = 1'b0;
              s.sda     = s.shift[MSB];
              s.sda_rel = 1'b0;
            end else begin
              s.scl   = 1'b1;
              s.shift = {s.shift[MSB-1:0], 1'b0};
            end
          end else if (s.phase == i2cmbe_pkg::BIT_PHASES) begin
            s.scl = 1'b0; s.sda = 1'b1; s.sda_rel = 1'b1;
          end else begin
            s.scl      = 1'b1;
            s.ack_flag = sda_in_i;
          end
        end
        i2cmbe_pkg::CMD_READ: begin
          last = i2cmbe_pkg::XFER_LAST;
          if (s.phase < i2cmbe_pkg::BIT_PHASES) begin
            if (!s.phase[0]) begin
              if (s.phase == 5'd0) begin
                s.sda = 1'b1; s.sda_rel = 1'b1;
              end else begin
                s.scl = 1'b0;
              end
            end else begin
              s.scl   = 1'b1;
              s.shift = {s.shift[MSB-1:0], sda_in_i};
              if (s.phase == i2cmbe_pkg::BIT_PHASES - 5'd1) s.rx = s.shift;
            end
          end else if (s.phase == i2cmbe_pkg::BIT_PHASES) begin
            s.scl = 1'b0; s.sda = !s.ack_choice; s.sda_rel = 1'b0;
          end else begin
            s.scl = 1'b1;
          end
        end
        default: begin
          last = '0;
        end
      endcase
      done = (s.phase >= last);
      if (!done) s.phase = s.phase + 5'd1;
    end

    res_o.scl_level = s.scl;
    res_o.scl_drive = pp_mode_i | ~s.scl;
    res_o.sda_level = s.sda_rel | s.sda;
    res_o.sda_drive = !s.sda_rel && (pp_mode_i || !s.sda);
    res_o.busy_res  = busy;
    res_o.done_res  = done;
    res_o.rx_byte   = s.rx;
    res_o.ack_seen  = s.ack_flag;

    // bus handed back after a byte transfer
    if (done) begin
      if (s.active == i2cmbe_pkg::CMD_WRITE || s.active == i2cmbe_pkg::CMD_READ) begin
        s.scl = 1'b0; s.sda = 1'b1; s.sda_rel = 1'b1;
      end
      s.active = i2cmbe_pkg::CMD_NONE;
      s.phase  = '0;
    end

    state_o = s;
  end

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// i2c master byte engine testbench
// plays start, stop, write and read sequences one half-period word at a time,
// predicts the scl/sda levels, drive enables and status of every result word
// and compares them field by field, in open-drain and push-pull modes, with
// random idling on the input and result channels
// ----------------------------------------------------------------------------
module testbench;

  class bus_level_predictor;
    bit                 push_pull;
    i2cmbe_pkg::cmd_t   act;
    logic [4:0]         phase;
    logic [7:0]         shift, rx_hold;
    logic               ack_flag, ack_choice, scl, sda, sda_rel;
    i2cmbe_pkg::res_t   expected_levels[$];
    int                 errors;

    function new();
      push_pull  = 1'b0;
      act        = i2cmbe_pkg::CMD_NONE;
      phase      = '0;
      shift      = '0;
      rx_hold    = '0;
      ack_flag   = 1'b1;
      ack_choice = 1'b0;
      scl        = 1'b1;
      sda        = 1'b1;
      sda_rel    = 1'b0;
      errors     = 0;
    endfunction

    function int pending();
      return expected_levels.size();
    endfunction

    function void set_mode(logic v);
      push_pull = v;
    endfunction

    function void drive_sda(logic v);
      sda     = v;
      sda_rel = 1'b0;
    endfunction

    function void free_sda();
      sda     = 1'b1;
      sda_rel = 1'b1;
    endfunction

    function void note_word(logic [15:0] w);
      logic [2:0]       c;
      logic             sda_in;
      logic             busy, done;
      logic [4:0]       p, fin_phase;
      i2cmbe_pkg::res_t r;
      c      = w[2:0];
      sda_in = w[12];
      busy   = 1'b0;
      done   = 1'b0;
      fin_phase = '0;
      if (act == i2cmbe_pkg::CMD_NONE &&
          c >= i2cmbe_pkg::CMD_START && c <= i2cmbe_pkg::CMD_READ) begin
        act   = i2cmbe_pkg::cmd_t'(c);
        phase = '0;
        if (act == i2cmbe_pkg::CMD_WRITE) shift = w[10:3];
        else if (act == i2cmbe_pkg::CMD_READ) shift = '0;
        ack_choice = w[11];
      end
      if (act != i2cmbe_pkg::CMD_NONE) begin
        busy = 1'b1;
        p    = phase;
        case (act)
          i2cmbe_pkg::CMD_START: begin
            fin_phase = i2cmbe_pkg::START_LAST;
            case (p)
              5'd0: drive_sda(1'b1);
              5'd1: scl = 1'b1;
              5'd2: drive_sda(1'b0);
              default: scl = 1'b0;
            endcase
          end
          i2cmbe_pkg::CMD_STOP: begin
            fin_phase = i2cmbe_pkg::STOP_LAST;
            case (p)
              5'd0: drive_sda(1'b0);
              5'd1: scl = 1'b1;
              default: drive_sda(1'b1);
            endcase
          end
          i2cmbe_pkg::CMD_WRITE: begin
            fin_phase = i2cmbe_pkg::XFER_LAST;
            if (p < i2cmbe_pkg::BIT_PHASES) begin
              if (!p[0]) begin
                if (p != 5'd0) scl = 1'b0;
                drive_sda(shift[7]);
              end else begin
                scl   = 1'b1;
                shift = shift << 1;
              end
            end else if (p == i2cmbe_pkg::BIT_PHASES) begin
              scl = 1'b0;
              free_sda();
            end else begin
              scl      = 1'b1;
              ack_flag = sda_in;
            end
          end
          default: begin
            fin_phase = i2cmbe_pkg::XFER_LAST;
            if (p < i2cmbe_pkg::BIT_PHASES) begin
              if (!p[0]) begin
                if (p == 5'd0) free_sda();
                else scl = 1'b0;
              end else begin
                scl   = 1'b1;
                shift = {shift[6:0], sda_in};
                if (p == i2cmbe_pkg::BIT_PHASES - 5'd1) rx_hold = shift;
              end
            end else if (p == i2cmbe_pkg::BIT_PHASES) begin
              scl = 1'b0;
              drive_sda(!ack_choice);
            end else begin
              scl = 1'b1;
            end
          end
        endcase
        if (p >= fin_phase) done = 1'b1;
        else phase = p + 5'd1;
      end
      r.scl_level = scl;
      r.scl_drive = push_pull ? 1'b1 : !scl;
      r.sda_level = sda_rel ? 1'b1 : sda;
      r.sda_drive = sda_rel ? 1'b0 : (push_pull ? 1'b1 : !sda);
      r.busy_res  = busy;
      r.done_res  = done;
      r.rx_byte   = rx_hold;
      r.ack_seen  = ack_flag;
      expected_levels.push_back(r);
      if (done) begin
        if (act == i2cmbe_pkg::CMD_WRITE || act == i2cmbe_pkg::CMD_READ) begin
          scl = 1'b0;
          free_sda();
        end
        act   = i2cmbe_pkg::CMD_NONE;
        phase = '0;
      end
    endfunction

    function void cmp_field(string tag, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s expected %0h, got %0h", $time, tag, want, got);
      end
    endfunction

    function void check_word(logic [15:0] w);
      i2cmbe_pkg::res_t e, a;
      a = i2cmbe_pkg::res_t'(w[14:0]);
      if (expected_levels.size() == 0) begin
        errors++;
        $display("%0t: result word expected none, got %h", $time, w);
      end else begin
        e = expected_levels.pop_front();
        cmp_field("scl_level", e.scl_level, a.scl_level);
        cmp_field("scl_drive", e.scl_drive, a.scl_drive);
        cmp_field("sda_level", e.sda_level, a.sda_level);
        cmp_field("sda_drive", e.sda_drive, a.sda_drive);
        cmp_field("busy_res", e.busy_res, a.busy_res);
        cmp_field("done_res", e.done_res, a.done_res);
        cmp_field("rx_byte", e.rx_byte, a.rx_byte);
        cmp_field("ack_seen", e.ack_seen, a.ack_seen);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_data = 1'b0;

  bus_level_predictor sb;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int words_sent = 0;

  i2c_master_byte_engine_core uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  always @(negedge clk) begin
    if (recv_idle_pct > 0 && $urandom_range(0, 99) < recv_idle_pct) out_tready <= 1'b0;
    else out_tready <= 1'b1;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.set_mode(cfg_data);
      if (in_tvalid && in_tready) sb.note_word(in_tdata);
      if (out_tvalid && out_tready) sb.check_word(out_tdata);
    end
  end

  initial begin
    #(12 * 400000);
    $display("testbench NOT OK");
    $finish;
  end

  function automatic logic [15:0] item_word(logic [2:0] c, logic [7:0] b, logic ack,
                                            logic sda_in);
    return {3'b000, sda_in, ack, b, c};
  endfunction

  task automatic send_word(input logic [15:0] w);
    @(negedge clk);
    while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= w;
    do @(posedge clk); while (!in_tready);
    words_sent++;
  endtask

  // stray < 0: later words carry a random command now and then
  task automatic play_command(input logic [2:0] c, input logic [7:0] b, input logic ack,
                              input int stray, input int sda_fix);
    int       ticks;
    logic [2:0] sc;
    logic     s;
    ticks = (c == i2cmbe_pkg::CMD_START) ? int'(i2cmbe_pkg::START_LAST) + 1 :
            (c == i2cmbe_pkg::CMD_STOP) ? int'(i2cmbe_pkg::STOP_LAST) + 1 :
            int'(i2cmbe_pkg::XFER_LAST) + 1;
    for (int i = 0; i < ticks; i++) begin
      s = (sda_fix < 0) ? 1'($urandom_range(0, 1)) : 1'(sda_fix);
      if (i == 0) begin
        send_word(item_word(c, b, ack, s));
      end else begin
        if (stray >= 0) sc = 3'(stray);
        else if ($urandom_range(0, 9) == 0) sc = 3'($urandom_range(0, 7));
        else sc = i2cmbe_pkg::CMD_NONE;
        send_word(item_word(sc, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), s));
      end
    end
  endtask

  task automatic wait_drained();
    int n;
    n = 0;
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.pending() != 0 && n < 20000) begin
      @(posedge clk);
      n++;
    end
  endtask

  task automatic settle_idle();
    wait_drained();
    while (sb.act != i2cmbe_pkg::CMD_NONE) begin
      send_word(item_word(i2cmbe_pkg::CMD_NONE, 8'h00, 1'b0, 1'($urandom_range(0, 1))));
      wait_drained();
    end
  endtask

  task automatic write_mode(input logic v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_random(input int sp, input int rp, input int n_words);
    int         goal, r;
    logic [2:0] pc;
    send_idle_pct = sp;
    recv_idle_pct = rp;
    goal = words_sent + n_words;
    while (words_sent < goal) begin
      r = $urandom_range(0, 9);
      if (r == 9) begin
        send_word(item_word(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                            1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
      end else begin
        pc = (r < 2) ? i2cmbe_pkg::CMD_START :
             (r == 2) ? i2cmbe_pkg::CMD_STOP :
             (r < 6) ? i2cmbe_pkg::CMD_WRITE : i2cmbe_pkg::CMD_READ;
        play_command(pc, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), -1, -1);
      end
    end
    settle_idle();
  endtask

  initial begin
    sb = new();
    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    write_mode(1'b0);
    // start with a write arriving mid-sequence, unused codes, stop, read of all ones with ack
    play_command(i2cmbe_pkg::CMD_START, 8'hFF, 1'b1, i2cmbe_pkg::CMD_WRITE, -1);
    send_word(item_word(3'd5, 8'h00, 1'b0, 1'b0));
    send_word(item_word(3'd6, 8'hFF, 1'b1, 1'b1));
    send_word(item_word(3'd7, 8'h5A, 1'b0, 1'b0));
    play_command(i2cmbe_pkg::CMD_STOP, 8'h00, 1'b0, i2cmbe_pkg::CMD_NONE, 0);
    play_command(i2cmbe_pkg::CMD_READ, 8'h00, 1'b1, i2cmbe_pkg::CMD_NONE, 1);
    settle_idle();

    write_mode(1'b1);
    run_random(16, 54, 135);
    write_mode(1'b0);
    run_random(54, 16, 135);
    write_mode(1'b1);
    run_random(0, 0, 135);

    repeat (8) @(posedge clk);
    if (sb.pending() != 0) begin
      sb.errors++;
      $display("%0t: %0d result words expected, got none", $time, sb.pending());
    end
    if (sb.errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+design
design/i2cmbe_pkg.sv
design/i2cmbe_step.sv
design/i2c_master_byte_engine_core.sv
tb/testbench.sv
